// ===== src/wwdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwdr_pkg
// Shared widths, constants and item types of the weighted window retarget.
// ----------------------------------------------------------------------------
package wwdr_pkg;

  localparam int WINDOW    = 720;
  localparam int DATA_W    = 64;
  localparam int TGT_W     = 16;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = $clog2(WINDOW + 1);

  localparam int TGT_MAX   = (1 << TGT_W) - 1;
  localparam int CAP_MULT  = 10;
  localparam int SPAN_W    = $clog2(CAP_MULT * TGT_MAX + 1);
  localparam int FACT_PCT  = 99;
  localparam int FACT_DEN  = 100;

  localparam logic [TGT_W-1:0] TGT_RESET = TGT_W'(120);

  localparam longint unsigned FACT_MAX =
    (longint'(FACT_PCT) * longint'(WINDOW / 2) * longint'(TGT_MAX)) / longint'(FACT_DEN);
  localparam int FACT_W    = $clog2(FACT_MAX + 1);
  localparam int PROD_W    = DATA_W + FACT_W;

  localparam int M99_W     = CNT_W + $clog2(FACT_PCT + 1);
  localparam int MIN_W     = TGT_W + CNT_W;
  localparam int RAW_W     = M99_W + TGT_W;

  typedef struct packed {
    logic [DATA_W-1:0] block_time;
    logic [DATA_W-1:0] cumulative_work;
    logic              last_record;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] next_target_difficulty;
    logic              product_overflow;
  } result_t;

endpackage

// ===== src/wwdr_smul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwdr_smul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wwdr_smul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [wwdr_pkg::DATA_W-1:0]         mcand,
  input  logic [wwdr_pkg::FACT_W-1:0]         mplier,
  output logic                                done,
  output logic [wwdr_pkg::PROD_W-1:0]         prod
);

  localparam int DW = wwdr_pkg::DATA_W;
  localparam int FW = wwdr_pkg::FACT_W;
  localparam int PW = wwdr_pkg::PROD_W;
  localparam int CW = $clog2(FW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] md;
  logic [DW:0]   acc;

  assign acc = {1'b0, prod[PW-1:FW]} + (prod[0] ? {1'b0, md} : {(DW + 1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(FW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      md   <= mcand;
      prod <= {{DW{1'b0}}, mplier};
    end else if (busy) begin
      prod <= {acc, prod[FW-1:1]};
    end
  end

endmodule

// ===== src/wwdr_sdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwdr_sdiv
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wwdr_sdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wwdr_pkg::DATA_W-1:0] dividend,
  input  logic [wwdr_pkg::SUM_W-1:0]  divisor,
  output logic                        done,
  output logic [wwdr_pkg::DATA_W-1:0] quot
);

  localparam int DW = wwdr_pkg::DATA_W;
  localparam int SW = wwdr_pkg::SUM_W;
  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [SW-1:0] den;
  logic [SW-1:0] rem;
  logic [SW:0]   sh;
  logic [SW:0]   diff;
  logic          ge;

  assign sh   = {rem, quot[DW-1]};
  assign diff = sh - {1'b0, den};
  assign ge   = (sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den  <= divisor;
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      rem  <= ge ? diff[SW-1:0] : sh[SW-1:0];
      quot <= {quot[DW-2:0], ge};
    end
  end

endmodule

// ===== src/weighted_window_difficulty_retarget.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_window_difficulty_retarget
// Weighted timespan difficulty retarget over a window of block records.
// A counted record after the first has its span weighted in the shared
//   bit-serial multiplier; other records are taken without it.
// A last record then runs the final steps: divide by 100 for the factor,
//   product multiply and, unless it overflows, sum divide; a lone record gives 1.
// One item is in flight at a time.
// Synchronous reset restores the target to 120 and clears the series state.
// ----------------------------------------------------------------------------
module weighted_window_difficulty_retarget (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  wwdr_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output wwdr_pkg::result_t          result,
  input  logic                       cfg_write,
  input  logic [wwdr_pkg::TGT_W-1:0] cfg_data
);

  localparam int DW  = wwdr_pkg::DATA_W;
  localparam int TW  = wwdr_pkg::TGT_W;
  localparam int SW  = wwdr_pkg::SUM_W;
  localparam int NW  = wwdr_pkg::CNT_W;
  localparam int PW  = wwdr_pkg::SPAN_W;
  localparam int FW  = wwdr_pkg::FACT_W;
  localparam int QW  = wwdr_pkg::PROD_W;
  localparam int M9W = wwdr_pkg::M99_W;
  localparam int MNW = wwdr_pkg::MIN_W;
  localparam int RW  = wwdr_pkg::RAW_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SPAN_GO   = 4'd1;
  localparam logic [3:0] S_SPAN_WAIT = 4'd2;
  localparam logic [3:0] S_FIN       = 4'd3;
  localparam logic [3:0] S_RAW       = 4'd4;
  localparam logic [3:0] S_D100_GO   = 4'd5;
  localparam logic [3:0] S_D100_WAIT = 4'd6;
  localparam logic [3:0] S_PMUL_GO   = 4'd7;
  localparam logic [3:0] S_PMUL_WAIT = 4'd8;
  localparam logic [3:0] S_DIV_GO    = 4'd9;
  localparam logic [3:0] S_DIV_WAIT  = 4'd10;
  localparam logic [3:0] S_OUT       = 4'd11;

  logic [3:0]        state;
  logic [TW-1:0]     target;
  logic [PW-1:0]     cap;
  logic [NW-1:0]     seen;
  logic [DW-1:0]     prev_time;
  logic [DW-1:0]     first_work;
  logic [DW-1:0]     latest_work;
  logic [SW-1:0]     sum;
  logic [PW-1:0]     span;
  logic              last_pend;
  logic [M9W-1:0]    m99;
  logic [MNW-1:0]    minimum;
  logic [DW-1:0]     span_work;
  logic [DW-1:0]     raw;
  logic [SW-1:0]     sum_c;
  logic [FW-1:0]     factor;
  wwdr_pkg::result_t res;

  logic              accept;
  logic              counted;
  logic [DW:0]       diff;
  logic              pos;
  logic [PW-1:0]     span_next;
  logic [SW-1:0]     sum_max;
  logic [SW-1:0]     sum_c_next;

  logic              mul_start;
  logic              mul_done;
  logic [DW-1:0]     mul_mcand;
  logic [FW-1:0]     mul_mplier;
  logic [QW-1:0]     mul_prod;
  logic              div_start;
  logic              div_done;
  logic [SW-1:0]     div_den;
  logic [DW-1:0]     div_quot;

  assign item_stall = rst || (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign counted    = (seen < NW'(wwdr_pkg::WINDOW));

  assign cap = PW'(target) * PW'(wwdr_pkg::CAP_MULT);

  assign diff = {1'b0, item.block_time} - {1'b0, prev_time};
  assign pos  = !diff[DW] && (diff[DW-1:0] != '0);

  always_comb begin
    if (!pos) begin
      span_next = PW'(1);
    end else if ((|diff[DW-1:PW]) || (diff[PW-1:0] > cap)) begin
      span_next = cap;
    end else begin
      span_next = diff[PW-1:0];
    end
    if (span_next > cap) begin
      span_next = cap;
    end
  end

  assign sum_max    = (sum >= SW'(minimum)) ? sum : SW'(minimum);
  assign sum_c_next = (sum_max == '0) ? SW'(1) : sum_max;

  assign mul_start  = (state == S_SPAN_GO) || (state == S_PMUL_GO);
  assign mul_mcand  = (state == S_PMUL_GO) ? span_work : DW'(span);
  assign mul_mplier = (state == S_PMUL_GO) ? factor : FW'(seen - 1'b1);

  assign div_start  = (state == S_D100_GO) || (state == S_DIV_GO);
  assign div_den    = (state == S_DIV_GO) ? sum_c : SW'(wwdr_pkg::FACT_DEN);

  wwdr_smul u_smul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  wwdr_sdiv u_sdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (raw),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= wwdr_pkg::TGT_RESET;
    end else begin
      if (cfg_write) begin
        target <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      seen         <= '0;
      prev_time    <= '0;
      first_work   <= '0;
      latest_work  <= '0;
      sum          <= '0;
      last_pend    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_pend <= item.last_record;
            if (counted) begin
              prev_time   <= item.block_time;
              latest_work <= item.cumulative_work;
              seen        <= seen + 1'b1;
              if (seen == '0) begin
                first_work <= item.cumulative_work;
              end
            end
            if (counted && (seen != '0)) begin
              span  <= span_next;
              state <= S_SPAN_GO;
            end else if (item.last_record) begin
              state <= S_FIN;
            end
          end
        end
        S_SPAN_GO: begin
          state <= S_SPAN_WAIT;
        end
        S_SPAN_WAIT: begin
          if (mul_done) begin
            sum   <= sum + mul_prod[SW-1:0];
            state <= last_pend ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (seen <= NW'(1)) begin
            res.next_target_difficulty <= DW'(1);
            res.product_overflow       <= 1'b0;
            state                      <= S_OUT;
          end else begin
            m99       <= M9W'(seen >> 1) * M9W'(wwdr_pkg::FACT_PCT);
            minimum   <= (MNW'(target) * MNW'(seen - 1'b1)) >> 1;
            span_work <= latest_work - first_work;
            state     <= S_RAW;
          end
        end
        S_RAW: begin
          raw   <= DW'(RW'(m99) * RW'(target));
          sum_c <= sum_c_next;
          state <= S_D100_GO;
        end
        S_D100_GO: begin
          state <= S_D100_WAIT;
        end
        S_D100_WAIT: begin
          if (div_done) begin
            factor <= div_quot[FW-1:0];
            state  <= S_PMUL_GO;
          end
        end
        S_PMUL_GO: begin
          state <= S_PMUL_WAIT;
        end
        S_PMUL_WAIT: begin
          if (mul_done) begin
            if (|mul_prod[QW-1:DW]) begin
              res.next_target_difficulty <= '0;
              res.product_overflow       <= 1'b1;
              state                      <= S_OUT;
            end else begin
              raw   <= mul_prod[DW-1:0];
              state <= S_DIV_GO;
            end
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res.next_target_difficulty <= div_quot;
            res.product_overflow       <= 1'b0;
            state                      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result       <= res;
            result_valid <= 1'b1;
            seen         <= '0;
            prev_time    <= '0;
            first_work   <= '0;
            latest_work  <= '0;
            sum          <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/wwdr_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwdr_check
// Port-level checks on the retarget block, attached by bind.
// ----------------------------------------------------------------------------
module wwdr_check (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input wwdr_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input wwdr_pkg::result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result item changed while stalled");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.product_overflow |-> result.next_target_difficulty == '0)
    else $error("overflow result is not zero");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.last_record |=> item_stall)
    else $error("last item did not start the final computation");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared without the block being busy");

endmodule

bind weighted_window_difficulty_retarget wwdr_check u_wwdr_check (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== sim/weighted_window_difficulty_retarget_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_window_difficulty_retarget_tb
// Self-checking bench for the weighted window retarget. Block records are sent
// as single series and as random series of timestamps and work values, under
// several target settings. A scoreboard class predicts each retarget result
// and checks what comes out. Items idle and results stall at random.
// ----------------------------------------------------------------------------
module weighted_window_difficulty_retarget_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int TW          = wwdr_pkg::TGT_W;
  localparam int DW          = wwdr_pkg::DATA_W;
  localparam int SW          = wwdr_pkg::SUM_W;

  class retarget_scoreboard;
    logic [TW-1:0]     target;
    logic [12:0]       count;
    logic [DW-1:0]     prev_time;
    logic [DW-1:0]     first_work;
    logic [DW-1:0]     latest_work;
    logic [SW-1:0]     span_sum;
    wwdr_pkg::result_t expected_q[$];
    int                errors;

    function new();
      target = wwdr_pkg::TGT_RESET;
      errors = 0;
      clear_series();
    endfunction

    function void clear_series();
      count       = '0;
      prev_time   = '0;
      first_work  = '0;
      latest_work = '0;
      span_sum    = '0;
    endfunction

    function void set_target(logic [TW-1:0] v);
      target = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(wwdr_pkg::item_t it);
      logic [63:0]       span;
      logic [63:0]       cap;
      logic [63:0]       weighted;
      logic [63:0]       floor_sum;
      logic [63:0]       sum;
      logic [63:0]       factor;
      logic [63:0]       work_span;
      logic [127:0]      product;
      wwdr_pkg::result_t r;
      if (count < wwdr_pkg::WINDOW) begin
        if (count == 0) begin
          first_work = it.cumulative_work;
        end else begin
          span = (prev_time >= it.block_time) ? 64'd1 : it.block_time - prev_time;
          cap  = 64'(target) * 64'(wwdr_pkg::CAP_MULT);
          if (span > cap) span = cap;
          weighted = 64'(count) * span;
          span_sum = span_sum + weighted[SW-1:0];
        end
        prev_time   = it.block_time;
        latest_work = it.cumulative_work;
        count       = count + 1'b1;
      end
      if (!it.last_record) return;
      if (count <= 1) begin
        r.next_target_difficulty = 64'd1;
        r.product_overflow       = 1'b0;
      end else begin
        sum       = 64'(span_sum);
        floor_sum = 64'(target) * (64'(count) - 64'd1) / 64'd2;
        work_span = latest_work - first_work;
        factor    = 64'(wwdr_pkg::FACT_PCT) * (64'(count) / 64'd2) * 64'(target)
                    / 64'(wwdr_pkg::FACT_DEN);
        if (sum < floor_sum) sum = floor_sum;
        if (sum == 0) sum = 64'd1;
        product = 128'(work_span) * 128'(factor);
        if (product[127:64] != 0) begin
          r.next_target_difficulty = 64'd0;
          r.product_overflow       = 1'b1;
        end else begin
          r.next_target_difficulty = product[63:0] / sum;
          r.product_overflow       = 1'b0;
        end
      end
      expected_q.push_back(r);
      clear_series();
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(wwdr_pkg::result_t got);
      wwdr_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.next_target_difficulty !== want.next_target_difficulty)
        report_mismatch($sformatf("difficulty %h, expected %h",
                                  got.next_target_difficulty, want.next_target_difficulty));
      if (got.product_overflow !== want.product_overflow)
        report_mismatch($sformatf("overflow flag %b, expected %b",
                                  got.product_overflow, want.product_overflow));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  wwdr_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  wwdr_pkg::result_t result;
  logic              cfg_write = 1'b0;
  logic [TW-1:0]     cfg_data = '0;

  retarget_scoreboard sb;
  bit                 calm = 1'b0;
  int                 quiet_cycles = 0;

  weighted_window_difficulty_retarget dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(input wwdr_pkg::item_t it);
    if (!calm && $urandom_range(99) < 14) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  task automatic send_rec(input logic [63:0] t, input logic [63:0] w, input logic last);
    wwdr_pkg::item_t it;
    it.block_time      = t;
    it.cumulative_work = w;
    it.last_record     = last;
    send_item(it);
  endtask

  // tidy series climb in work and mostly in time; the rest is raw noise with stray ends
  task automatic send_chain(input int len, input bit tidy);
    wwdr_pkg::item_t it;
    logic [63:0]     t;
    logic [63:0]     w;
    int              k;
    t = rand64() >> 2;
    w = rand64() >> $urandom_range(1, 40);
    for (k = 0; k < len; k++) begin
      if (tidy) begin
        case ($urandom_range(19))
          0: t = t - $urandom_range(1, 1000);
          1: ;
          2: t = t + 64'(sb.target) * $urandom_range(10, 30);
          default: t = t + $urandom_range(1, 2 * sb.target + 1);
        endcase
        w = w + (rand64() >> $urandom_range(16, 63));
        it.last_record = (k == len - 1);
      end else begin
        t = rand64();
        w = rand64();
        it.last_record = (k == len - 1) || ($urandom_range(5) == 0);
      end
      it.block_time      = t;
      it.cumulative_work = w;
      send_item(it);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_target(input logic [TW-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_target(v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) sb.check_result(result);
      result_stall <= !calm && ($urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [TW-1:0] targets[5];
    int            phase;
    int            sent;
    int            len;
    int            pick;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset target of 120
    send_rec(64'd0, 64'd0, 1'b1);
    send_rec('1, '1, 1'b0);
    send_rec(64'd0, 64'd0, 1'b1);
    send_rec(64'd1000, 64'd5, 1'b0);
    send_rec(64'd1000, 64'd10, 1'b0);
    send_rec(64'd1000, 64'd15, 1'b1);
    send_rec(64'd0, 64'd0, 1'b0);
    send_rec('1, 64'h8000_0000_0000_0000, 1'b1);
    send_rec(64'd10, 64'd0, 1'b0);
    send_rec(64'd210, 64'd1_000_000_000_000, 1'b0);
    send_rec(64'd410, 64'd2_000_000_000_000, 1'b0);
    send_rec(64'd610, 64'd3_000_000_000_000, 1'b1);
    send_rec(64'd0, 64'h5555_5555_5555_5555, 1'b0);
    send_rec(64'd1200, 64'h5555_5555_5555_6000, 1'b0);
    send_rec(64'd2401, 64'h5555_5555_5556_0000, 1'b1);
    drain();
    write_target('1);
    send_rec(64'h5555_5555_5555_5555, 64'd0, 1'b0);
    send_rec(64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_FFFF_FFFF_FFFF, 1'b0);
    send_rec(64'hAAAA_AAAA_AAAA_AAAB, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    drain();
    write_target(TW'(1));
    send_rec(64'd5, 64'd100, 1'b0);
    send_rec(64'd3, 64'd7100, 1'b1);
    drain();

    targets[0] = '1;
    targets[1] = TW'(1);
    targets[2] = TW'($urandom_range(1, wwdr_pkg::TGT_MAX));
    targets[3] = TW'($urandom_range(2, 300));
    targets[4] = wwdr_pkg::TGT_RESET;
    for (phase = 0; phase < 5; phase++) begin
      write_target(targets[phase]);
      calm = (phase == 3);
      sent = 0;
      if (phase == 3) begin
        // one series running past the window
        send_chain(wwdr_pkg::WINDOW + 4, 1'b1);
      end else begin
        while (sent < 16) begin
          pick = $urandom_range(19);
          if (pick == 0) len = 1;
          else if (pick < 3) len = $urandom_range(20, 60);
          else len = $urandom_range(2, 10);
          send_chain(len, $urandom_range(9) < 8);
          sent += len;
        end
      end
      drain();
    end
    calm = 1'b0;

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
